// ===== hw/rtl/pressure_valve_regulator_defines.svh =====
// ----------------------------------------------------------------------------
// Pressure valve regulator assertion macros
// Shared property forms for the checker file of the regulator.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_VALVE_REGULATOR_DEFINES_SVH
`define PRESSURE_VALVE_REGULATOR_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define PVR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pvr check failed: same-cycle implication");

// Next-cycle implication, off while reset is held.
`define PVR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pvr check failed: next-cycle implication");

`endif

// ===== hw/rtl/pvr_pkg.sv =====
// ----------------------------------------------------------------------------
// Pressure valve regulator package
// Widths, pressure constants, register indexes and inter-module structs.
// ----------------------------------------------------------------------------
`default_nettype none

package pvr_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned PSI_W  = 16;
  localparam int unsigned BTN_W  = 6;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // History of pressure samples, zero entries count as empty
  localparam int unsigned HISTORY_DEPTH = 8;
  localparam int unsigned HIST_SUM_W = PSI_W + $clog2(HISTORY_DEPTH);
  localparam int unsigned HIST_CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned HIST_MUL_W = PSI_W + HIST_CNT_W;

  // 8.8 psi constants
  localparam logic [PSI_W-1:0] PSI_HALF       = 16'd128;   // 0.5 psi
  localparam logic [PSI_W-1:0] PSI_MAX_TARGET = 16'd12800; // 50 psi
  localparam logic [PSI_W-1:0] PSI_PRESET3    = 16'd4352;  // 17 psi
  localparam logic [PSI_W-1:0] PSI_PRESET4    = 16'd12800; // 50 psi
  localparam logic [PSI_W-1:0] PSI_PRESET5    = 16'd11520; // 45 psi
  localparam logic [PSI_W-1:0] PSI_PRESET6    = 16'd6016;  // 23.5 psi
  localparam logic [PSI_W-1:0] VENT_MIN_DIFF  = 16'd77;    // just above 0.3 psi

  // diff / 1280 = (diff >> 8) / 5, the /5 as multiply by 205 and shift by 10
  localparam int unsigned DIV5_IN_W  = 8;
  localparam int unsigned DIV5_SHIFT = 10;
  localparam logic [DIV5_IN_W-1:0] DIV5_MUL = 8'd205;

  // reset values of the registers
  localparam logic [CFG_W-1:0] STABLE_TOL_RST  = 16'd128;
  localparam logic [CFG_W-1:0] SETTLE_MS_RST   = 16'd1000;
  localparam logic [CFG_W-1:0] MIN_OPEN_MS_RST = 16'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STABLE_TOL  = 2'd0,
    CFG_SETTLE_MS   = 2'd1,
    CFG_MIN_OPEN_MS = 2'd2
  } cfg_idx_e;

  // commands from the control path to the valve unit
  typedef struct packed {
    logic             smart_step;
    logic             manual_step;
    logic             man_fill;
    logic             man_vent;
    logic             open_fill;
    logic             open_vent;
    logic             clr_dur;
    logic [PSI_W-1:0] dur;
  } valve_cmd_t;

  // valve drive after the step
  typedef struct packed {
    logic fill_open;
    logic vent_open;
  } valve_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pvr_target_ctl.sv =====
// ----------------------------------------------------------------------------
// Target stepping
// Button release detection and target step, preset and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module pvr_target_ctl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic [pvr_pkg::BTN_W-1:0]      buttons_i,
  input  logic [pvr_pkg::PSI_W-1:0]      target_i,
  output logic [pvr_pkg::PSI_W-1:0]      target_o
);

  logic [pvr_pkg::BTN_W-1:0] held_q, held_d;
  logic                      rel0, rel1, poll1;
  logic [pvr_pkg::BTN_W-1:2] rel_hi;
  logic [pvr_pkg::PSI_W:0]   t_step, t_set;

  always_comb begin
    rel0   = ~buttons_i[0] & held_q[0];
    // button 2 is polled only when button 1 gave no release
    poll1  = ~rel0;
    rel1   = poll1 & ~buttons_i[1] & held_q[1];
    rel_hi = ~buttons_i[pvr_pkg::BTN_W-1:2] & held_q[pvr_pkg::BTN_W-1:2];

    held_d = held_q;
    if (step_i) begin
      held_d = {buttons_i[pvr_pkg::BTN_W-1:2], (poll1 ? buttons_i[1] : held_q[1]),
                buttons_i[0]};
    end

    if (rel0) begin
      t_step = (target_i >= pvr_pkg::PSI_HALF) ?
               {1'b0, target_i - pvr_pkg::PSI_HALF} : '0;
    end else if (rel1) begin
      t_step = {1'b0, target_i} + {1'b0, pvr_pkg::PSI_HALF};
    end else begin
      t_step = {1'b0, target_i};
    end

    // the later preset wins
    if (rel_hi[5]) begin
      t_set = {1'b0, pvr_pkg::PSI_PRESET6};
    end else if (rel_hi[4]) begin
      t_set = {1'b0, pvr_pkg::PSI_PRESET5};
    end else if (rel_hi[3]) begin
      t_set = {1'b0, pvr_pkg::PSI_PRESET4};
    end else if (rel_hi[2]) begin
      t_set = {1'b0, pvr_pkg::PSI_PRESET3};
    end else begin
      t_set = t_step;
    end

    target_o = (t_set > {1'b0, pvr_pkg::PSI_MAX_TARGET}) ?
               pvr_pkg::PSI_MAX_TARGET : t_set[pvr_pkg::PSI_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else begin
      held_q <= held_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pvr_history.sv =====
// ----------------------------------------------------------------------------
// Pressure history
// Sample shift line with running sum and nonzero count, deviation test.
// ----------------------------------------------------------------------------
`default_nettype none

module pvr_history (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [pvr_pkg::PSI_W-1:0] pressure_i,
  input  logic [pvr_pkg::CFG_W-1:0] tolerance_i,
  output logic                      near_avg_o
);

  localparam int unsigned DEPTH = pvr_pkg::HISTORY_DEPTH;
  localparam int unsigned SUM_W = pvr_pkg::HIST_SUM_W;
  localparam int unsigned CNT_W = pvr_pkg::HIST_CNT_W;
  localparam int unsigned MUL_W = pvr_pkg::HIST_MUL_W;

  logic [pvr_pkg::PSI_W-1:0] hist_q [DEPTH];
  logic [SUM_W-1:0]          sum_q, sum_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d, cnt_eff;
  logic [pvr_pkg::PSI_W-1:0] oldest;
  logic [MUL_W-1:0]          sum_ext, scaled_p, dev, tol_scaled;

  always_comb begin
    oldest  = hist_q[DEPTH-1];
    // zero entries add nothing to the sum, so only the count needs the test
    sum_d   = sum_q + SUM_W'(pressure_i) - SUM_W'(oldest);
    cnt_d   = cnt_q + CNT_W'(pressure_i != '0) - CNT_W'(oldest != '0);
    cnt_eff = (cnt_d == '0) ? CNT_W'(1) : cnt_d;

    sum_ext    = MUL_W'(sum_d);
    scaled_p   = MUL_W'(pressure_i) * MUL_W'(cnt_d);
    dev        = (sum_ext > scaled_p) ? sum_ext - scaled_p : scaled_p - sum_ext;
    tol_scaled = MUL_W'(tolerance_i) * MUL_W'(cnt_eff);
    near_avg_o = dev < tol_scaled;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        hist_q[i] <= '0;
      end
      sum_q <= '0;
      cnt_q <= '0;
    end else if (step_i) begin
      for (int i = DEPTH - 1; i > 0; i--) begin
        hist_q[i] <= hist_q[i-1];
      end
      hist_q[0] <= pressure_i;
      sum_q     <= sum_d;
      cnt_q     <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pvr_valve.sv =====
// ----------------------------------------------------------------------------
// Valve unit
// Valve open state, open times, durations, expiry and settle timing.
// ----------------------------------------------------------------------------
`default_nettype none

module pvr_valve (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [pvr_pkg::TIME_W-1:0] now_i,
  input  logic [pvr_pkg::CFG_W-1:0]  settle_ms_i,
  input  pvr_pkg::valve_cmd_t        cmd_i,
  output logic                       settled_o,
  output pvr_pkg::valve_sts_t        sts_o
);

  localparam int unsigned TW = pvr_pkg::TIME_W;

  logic                      fill_q, fill_d, vent_q, vent_d;
  logic [TW-1:0]             fill_at_q, fill_at_d, vent_at_q, vent_at_d;
  logic [pvr_pkg::PSI_W-1:0] fill_dur_q, fill_dur_d, vent_dur_q, vent_dur_d;
  logic [TW-1:0]             sref_q, sref_d;
  logic [TW-1:0]             fill_el, vent_el, fill_el2, vent_el2;
  logic                      both_closed, fill1, vent1;

  always_comb begin
    fill_el     = now_i - fill_at_q;
    vent_el     = now_i - vent_at_q;
    both_closed = !fill_q && !vent_q;
    settled_o   = both_closed && ((now_i - sref_q) > TW'(settle_ms_i));

    // first expiry pass on the state held before this word
    fill1 = fill_q && !(fill_el > TW'(fill_dur_q));
    vent1 = vent_q && !(vent_el > TW'(vent_dur_q));

    fill_d     = fill_q;
    vent_d     = vent_q;
    fill_at_d  = fill_at_q;
    vent_at_d  = vent_at_q;
    fill_dur_d = fill_dur_q;
    vent_dur_d = vent_dur_q;
    sref_d     = sref_q;
    fill_el2   = fill_el;
    vent_el2   = vent_el;

    if (cmd_i.manual_step) begin
      fill_d = cmd_i.man_fill;
      vent_d = cmd_i.man_vent;
      if (cmd_i.man_fill) begin
        fill_at_d = now_i;
      end
      if (cmd_i.man_vent) begin
        vent_at_d = now_i;
      end
    end else if (cmd_i.smart_step) begin
      if (!both_closed) begin
        sref_d = now_i;
      end
      if (cmd_i.clr_dur) begin
        fill_dur_d = '0;
        vent_dur_d = '0;
      end
      if (cmd_i.open_fill) begin
        fill_dur_d = cmd_i.dur;
        fill_at_d  = now_i;
        fill_el2   = '0;
      end
      if (cmd_i.open_vent) begin
        vent_dur_d = cmd_i.dur;
        vent_at_d  = now_i;
        vent_el2   = '0;
      end
      // second expiry pass on the updated times and durations
      fill_d = (fill1 || cmd_i.open_fill) && !(fill_el2 > TW'(fill_dur_d));
      vent_d = (vent1 || cmd_i.open_vent) && !(vent_el2 > TW'(vent_dur_d));
    end

    sts_o.fill_open = fill_d;
    sts_o.vent_open = vent_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= 1'b0;
      vent_q     <= 1'b0;
      fill_at_q  <= '0;
      vent_at_q  <= '0;
      fill_dur_q <= '0;
      vent_dur_q <= '0;
      sref_q     <= '0;
    end else begin
      fill_q     <= fill_d;
      vent_q     <= vent_d;
      fill_at_q  <= fill_at_d;
      vent_at_q  <= vent_at_d;
      fill_dur_q <= fill_dur_d;
      vent_dur_q <= vent_dur_d;
      sref_q     <= sref_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pressure_valve_regulator.sv =====
// ----------------------------------------------------------------------------
// Pressure valve regulator
// Per-sample control call: target handling, stability test, valve timing.
// ----------------------------------------------------------------------------
//  Channel    Dir  Handshake              Payload
//  s_axis     in   tvalid/tready          now_ms, pressure, buttons; tuser manual
//  m_axis     out  tvalid/tready          fill_valve, vent_valve, target_psi, stable
//  cfg        in   cfg_we_i (no stall)    cfg_idx_i, cfg_wdata_i
//
//  One word per cycle sustained while the result side is not stalled. A word
//  sits in the input register after acceptance and moves into the result
//  register when it fires; all state updates happen as it fires.
//  Reset clears the control state and configuration registers to their
//  defaults at once; the payload and result data registers have no reset.
//  A stalled result holds the input register; the input takes a new word
//  whenever the result register frees up in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_valve_regulator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // [31:0] now_ms, [47:32] pressure, [53:48] buttons, [55:54] zero
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [55:0]                   s_axis_tdata_i,
  // [0] manual
  input  logic                          s_axis_tuser_i,
  // [0] fill_valve, [1] vent_valve, [17:2] target_psi, [18] stable, [23:19] zero
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [23:0]                   m_axis_tdata_o,
  input  logic                          cfg_we_i,
  input  logic [pvr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pvr_pkg::CFG_W-1:0]     cfg_wdata_i
);

  localparam int unsigned PW = pvr_pkg::PSI_W;

  // configuration
  logic [pvr_pkg::CFG_W-1:0] tol_q, settle_q, min_open_q;

  // input register
  logic                         in_valid_q;
  logic [pvr_pkg::TIME_W-1:0]   now_q;
  logic [PW-1:0]                p_q;
  logic [pvr_pkg::BTN_W-1:0]    btn_q;
  logic                         man_q;

  // control state
  logic [PW-1:0] target_q, target_d;
  logic          mmark_q, mmark_d;

  // result register
  logic          out_valid_q;
  logic          res_fill_q, res_vent_q, res_stable_q;
  logic [PW-1:0] res_target_q;

  logic                      fire, smart_fire, settled, near_avg, stable, leave;
  logic [PW-1:0]             tgt_step, diff;
  logic                      gt;
  logic [2*pvr_pkg::DIV5_IN_W-1:0] div_prod;
  logic [PW-1:0]             ms_raw, open_ms;
  logic [PW:0]               rounded;
  logic [PW-1:0]             rounded_sat;
  pvr_pkg::valve_cmd_t       cmd;
  pvr_pkg::valve_sts_t       sts;

  assign fire            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign smart_fire      = fire && !man_q;
  assign s_axis_tready_o = !in_valid_q || fire;

  pvr_target_ctl u_target (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (smart_fire),
    .buttons_i (btn_q),
    .target_i  (target_q),
    .target_o  (tgt_step)
  );

  pvr_history u_history (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (smart_fire),
    .pressure_i  (p_q),
    .tolerance_i (tol_q),
    .near_avg_o  (near_avg)
  );

  pvr_valve u_valve (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .now_i       (now_q),
    .settle_ms_i (settle_q),
    .cmd_i       (cmd),
    .settled_o   (settled),
    .sts_o       (sts)
  );

  always_comb begin
    stable = !man_q && settled && near_avg;
    leave  = stable && mmark_q;

    gt   = tgt_step > p_q;
    diff = gt ? tgt_step - p_q : p_q - tgt_step;

    // open time in ms: diff / 1280, at least min_open
    div_prod = (2*pvr_pkg::DIV5_IN_W)'(diff[PW-1:PW-pvr_pkg::DIV5_IN_W]) *
               (2*pvr_pkg::DIV5_IN_W)'(pvr_pkg::DIV5_MUL);
    ms_raw   = PW'(div_prod[2*pvr_pkg::DIV5_IN_W-1:pvr_pkg::DIV5_SHIFT]);
    open_ms  = (ms_raw < min_open_q) ? min_open_q : ms_raw;

    // round half up to whole psi, saturate
    rounded     = ({1'b0, p_q} + {1'b0, pvr_pkg::PSI_HALF}) & ~(PW+1)'(8'hFF);
    rounded_sat = rounded[PW] ? '1 : rounded[PW-1:0];

    cmd.smart_step  = smart_fire;
    cmd.manual_step = fire && man_q;
    cmd.man_fill    = btn_q[1];
    cmd.man_vent    = btn_q[0];
    cmd.open_fill   = stable && !mmark_q && gt;
    cmd.open_vent   = stable && !mmark_q && !gt && (diff >= pvr_pkg::VENT_MIN_DIFF);
    cmd.clr_dur     = leave;
    cmd.dur         = open_ms;

    target_d = target_q;
    mmark_d  = mmark_q;
    if (fire) begin
      if (man_q) begin
        target_d = p_q;
        mmark_d  = 1'b1;
      end else if (leave) begin
        target_d = rounded_sat;
        mmark_d  = 1'b0;
      end else begin
        target_d = tgt_step;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q      <= pvr_pkg::STABLE_TOL_RST;
      settle_q   <= pvr_pkg::SETTLE_MS_RST;
      min_open_q <= pvr_pkg::MIN_OPEN_MS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pvr_pkg::CFG_STABLE_TOL:  tol_q      <= cfg_wdata_i;
        pvr_pkg::CFG_SETTLE_MS:   settle_q   <= cfg_wdata_i;
        pvr_pkg::CFG_MIN_OPEN_MS: min_open_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      target_q    <= '0;
      mmark_q     <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      target_q <= target_d;
      mmark_q  <= mmark_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      now_q <= s_axis_tdata_i[31:0];
      p_q   <= s_axis_tdata_i[47:32];
      btn_q <= s_axis_tdata_i[53:48];
      man_q <= s_axis_tuser_i;
    end
    if (fire) begin
      res_fill_q   <= sts.fill_open;
      res_vent_q   <= sts.vent_open;
      res_target_q <= target_d;
      res_stable_q <= stable;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, res_stable_q, res_target_q, res_vent_q, res_fill_q};

endmodule

`default_nettype wire

// ===== hw/rtl/pvr_checker.sv =====
// ----------------------------------------------------------------------------
// Pressure valve regulator checker
// Port-level properties of the regulator, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pressure_valve_regulator_defines.svh"

module pvr_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tready_o,
  input  logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  input  logic [23:0] m_axis_tdata_o
);

  logic out_stall, stable_word, target_ok;

  assign out_stall   = m_axis_tvalid_o && !m_axis_tready_i;
  assign stable_word = m_axis_tvalid_o && m_axis_tdata_o[18];
  // clamped to 50 psi, rounded to whole psi, or saturated
  assign target_ok   = (m_axis_tdata_o[17:2] <= pvr_pkg::PSI_MAX_TARGET) ||
                       (m_axis_tdata_o[9:2] == 8'h00) ||
                       (m_axis_tdata_o[17:2] == 16'hFFFF);

  // input side never blocks while the result side moves
  `PVR_ASSERT_IMPL(a_in_ready_free, clk_i, rst_ni, !out_stall, s_axis_tready_o)

  // a stalled result word holds
  `PVR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // a stable call leaves the target clamped, rounded to whole psi, or saturated
  `PVR_ASSERT_IMPL(a_stable_target, clk_i, rst_ni, stable_word, target_ok)

endmodule

bind pressure_valve_regulator pvr_checker u_pvr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
